/* hw/rtl/fed_pkg.sv */
// Shared types and constants for the filename escape decoder.
// Used by fed_front, fed_queue, fed_back, the top level and the checker.
// No dependencies.
package fed_pkg;

  localparam int MAX_NAME_LEN = 1024;
  localparam int LEN_W        = 11;
  localparam int GROUP_MAX    = 3;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = 2;
  localparam int QCNT_W       = 3;
  localparam int ADDR_W       = 3;
  localparam int DATA_W       = 32;

  // Register indexes
  localparam logic REG_LOCAL_UTF8     = 1'b0;
  localparam logic REG_ESCAPE_WINDOWS = 1'b1;

  // Character codes
  localparam logic [7:0] CH_C2     = 8'hC2;
  localparam logic [7:0] CH_A0     = 8'hA0;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_QUEST  = 8'h3F;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LESS   = 8'h3C;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_GREAT  = 8'h3E;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UPA    = 8'h41;
  localparam logic [7:0] CH_UPF    = 8'h46;

  typedef struct packed {
    logic local_utf8;
    logic escape_windows;
  } cfg_t;

  // Results produced by one accepted byte, oldest in data[0]
  typedef struct packed {
    logic [GROUP_MAX-1:0][7:0] data;
    logic [1:0]                cnt;
    logic                      last;
  } group_t;

endpackage

/* hw/rtl/filename_escape_decoder_core.sv */
// Filename escape decoder top level: configuration registers, front part,
// group queue and back part. Depends on fed_pkg, fed_front, fed_queue, fed_back.
// A byte's group is queued when the byte is taken. Throughput: one byte per cycle
// in while the queue is not full; one result per pop out; a byte may yield up to
// three results, which leave over three pops while four queued groups absorb bursts.
// Reset (rst, synchronous): clears lookahead, queue, running length and both registers.
module filename_escape_decoder_core (
  input  logic                       clk,
  input  logic                       rst,
  // Configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [fed_pkg::ADDR_W-1:0] paddr,
  input  logic [fed_pkg::DATA_W-1:0] pwdata,
  output logic [fed_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  // Input side
  input  logic                       push,
  output logic                       full,
  input  logic [7:0]                 name_byte,
  input  logic                       last_in,
  // Result side
  output logic                       empty,
  input  logic                       pop,
  output logic [7:0]                 out_byte,
  output logic [fed_pkg::LEN_W-1:0]  length_so_far,
  output logic                       last_out
);

  fed_pkg::cfg_t   cfg;
  logic            cfg_wr;
  logic            reg_sel;
  logic            accept;
  logic            grp_push;
  fed_pkg::group_t grp_in;
  fed_pkg::group_t grp_head;
  logic            q_full;
  logic            q_empty;
  logic            q_pop;

  // Registers are word-addressed; the word index picks the register
  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        fed_pkg::REG_LOCAL_UTF8:     cfg.local_utf8 <= pwdata[0];
        fed_pkg::REG_ESCAPE_WINDOWS: cfg.escape_windows <= pwdata[0];
        default:                     cfg <= cfg;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      fed_pkg::REG_LOCAL_UTF8:     prdata[0] = cfg.local_utf8;
      fed_pkg::REG_ESCAPE_WINDOWS: prdata[0] = cfg.escape_windows;
      default:                     prdata[0] = 1'b0;
    endcase
  end

  // Take a byte whenever the queue has room for its group; the front
  // resolves the byte against the lookahead in the same cycle.
  assign full   = q_full;
  assign accept = push && !q_full;

  fed_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .accept    (accept),
    .name_byte (name_byte),
    .last_in   (last_in),
    .grp_push  (grp_push),
    .grp       (grp_in)
  );

  // Decouple the two sides: a waiting result never blocks the next byte
  // until four groups are pending.
  fed_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (grp_push),
    .wr_grp  (grp_in),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_grp  (grp_head),
    .q_empty (q_empty)
  );

  // Advance through the head group one byte per transfer
  fed_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (grp_head),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .pop           (pop),
    .empty         (empty),
    .out_byte      (out_byte),
    .length_so_far (length_so_far),
    .last_out      (last_out)
  );

endmodule

/* hw/rtl/fed_front.sv */
// Front part: accepts name bytes, matches escape sequences against the
// lookahead bytes and produces a group of one to three translated bytes.
// Depends on fed_pkg.
module fed_front (
  input  logic            clk,
  input  logic            rst,
  input  fed_pkg::cfg_t   cfg,
  input  logic            accept,
  input  logic [7:0]      name_byte,
  input  logic            last_in,
  output logic            grp_push,
  output fed_pkg::group_t grp
);

  logic [7:0] la0;
  logic [7:0] la1;
  logic [1:0] la_cnt;
  logic [7:0] la0_next;
  logic [7:0] la1_next;
  logic [1:0] la_cnt_next;

  logic [7:0] bytes [4];
  logic [7:0] obytes [3];
  logic [1:0] n;
  logic [1:0] pos;
  logic [1:0] avail;
  logic [1:0] ocnt;
  logic       stop;
  logic       fail;
  logic [7:0] b;
  logic [7:0] b1;
  logic [7:0] b2;
  logic [7:0] v;

  function automatic logic is_up_hex(input logic [7:0] c);
    is_up_hex = (c >= fed_pkg::CH_ZERO && c <= fed_pkg::CH_NINE) ||
                (c >= fed_pkg::CH_UPA && c <= fed_pkg::CH_UPF);
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] t;
    if (c <= fed_pkg::CH_NINE) begin
      t = c - fed_pkg::CH_ZERO;
    end else begin
      t = c - fed_pkg::CH_UPA + 8'd10;
    end
    hex_value = t[3:0];
  endfunction

  function automatic logic [7:0] map_single(input logic [7:0] c, input fed_pkg::cfg_t f);
    logic [7:0] r;
    r = c;
    if (c == fed_pkg::CH_SLASH) r = fed_pkg::CH_DOT;
    else if (c == fed_pkg::CH_A0 && !f.local_utf8) r = fed_pkg::CH_SPACE;
    else if (c == fed_pkg::CH_QUEST && f.escape_windows) r = fed_pkg::CH_HASH;
    else if (c == fed_pkg::CH_LESS && f.escape_windows) r = fed_pkg::CH_DOLLAR;
    else if (c == fed_pkg::CH_GREAT && f.escape_windows) r = fed_pkg::CH_CARET;
    map_single = r;
  endfunction

  function automatic logic [7:0] remap_decoded(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c == fed_pkg::CH_QUEST) r = fed_pkg::CH_HASH;
    else if (c == fed_pkg::CH_LESS) r = fed_pkg::CH_DOLLAR;
    else if (c == fed_pkg::CH_GREAT) r = fed_pkg::CH_CARET;
    remap_decoded = r;
  endfunction

  // Three passes cover the worst case: each pass consumes at least one byte
  always_comb begin
    bytes[0] = la0;
    bytes[1] = la1;
    bytes[2] = 8'h00;
    bytes[3] = 8'h00;
    bytes[la_cnt] = name_byte;
    n = la_cnt + 2'd1;
    pos = 2'd0;
    ocnt = 2'd0;
    stop = 1'b0;
    fail = 1'b0;
    avail = 2'd0;
    b = 8'h00;
    b1 = 8'h00;
    b2 = 8'h00;
    v = 8'h00;
    for (int k = 0; k < fed_pkg::GROUP_MAX; k++) begin
      obytes[k] = 8'h00;
    end
    for (int it = 0; it < fed_pkg::GROUP_MAX; it++) begin
      if (!stop && pos < n) begin
        b = bytes[pos];
        b1 = bytes[pos + 2'd1];
        b2 = bytes[pos + 2'd2];
        avail = n - pos;
        if (b == fed_pkg::CH_C2 && cfg.local_utf8) begin
          if (avail >= 2'd2) begin
            if (b1 == fed_pkg::CH_A0) begin
              obytes[ocnt] = fed_pkg::CH_SPACE;
              pos = pos + 2'd2;
            end else begin
              obytes[ocnt] = fed_pkg::CH_C2;
              pos = pos + 2'd1;
            end
            ocnt = ocnt + 2'd1;
          end else if (last_in) begin
            obytes[ocnt] = fed_pkg::CH_C2;
            pos = pos + 2'd1;
            ocnt = ocnt + 2'd1;
          end else begin
            stop = 1'b1;
          end
        end else if (b == fed_pkg::CH_QUEST) begin
          fail = 1'b0;
          priority if (avail >= 2'd2 && !is_up_hex(b1)) begin
            fail = 1'b1;
          end else if (avail == 2'd3 && !is_up_hex(b2)) begin
            fail = 1'b1;
          end else if (avail < 2'd3) begin
            if (last_in) fail = 1'b1;
            else stop = 1'b1;
          end else begin
            fail = 1'b0;
          end
          if (!stop) begin
            if (fail) begin
              obytes[ocnt] = map_single(b, cfg);
              pos = pos + 2'd1;
            end else begin
              v = {hex_value(b1), hex_value(b2)};
              obytes[ocnt] = remap_decoded(v);
              pos = pos + 2'd3;
            end
            ocnt = ocnt + 2'd1;
          end
        end else begin
          obytes[ocnt] = map_single(b, cfg);
          pos = pos + 2'd1;
          ocnt = ocnt + 2'd1;
        end
      end
    end

    // Hold what is left for the next byte; drop it all at end of name
    if (last_in) begin
      la0_next = 8'h00;
      la1_next = 8'h00;
      la_cnt_next = 2'd0;
    end else begin
      la0_next = bytes[pos];
      la1_next = bytes[pos + 2'd1];
      la_cnt_next = n - pos;
    end

    grp.data[0] = obytes[0];
    grp.data[1] = obytes[1];
    grp.data[2] = obytes[2];
    grp.cnt = ocnt;
    grp.last = last_in;
    grp_push = accept && (ocnt != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      la0 <= 8'h00;
      la1 <= 8'h00;
      la_cnt <= 2'd0;
    end else if (accept) begin
      la0 <= la0_next;
      la1 <= la1_next;
      la_cnt <= la_cnt_next;
    end
  end

endmodule

/* hw/rtl/fed_queue.sv */
// Short queue of result groups between the front and back parts.
// Depends on fed_pkg.
module fed_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  fed_pkg::group_t wr_grp,
  output logic            full,
  input  logic            rd_en,
  output fed_pkg::group_t rd_grp,
  output logic            q_empty
);

  fed_pkg::group_t                 slots [fed_pkg::QUEUE_DEPTH];
  logic [fed_pkg::QPTR_W-1:0]      wr_ptr;
  logic [fed_pkg::QPTR_W-1:0]      rd_ptr;
  logic [fed_pkg::QCNT_W-1:0]      count;
  logic                            do_wr;
  logic                            do_rd;

  assign full    = (count == fed_pkg::QCNT_W'(fed_pkg::QUEUE_DEPTH));
  assign q_empty = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_grp  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_grp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= rd_ptr + 1'b1;
      unique case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* hw/rtl/fed_back.sv */
// Back part: unpacks result groups one byte per transfer, keeps the
// saturating running length and marks the final byte of a name.
// Depends on fed_pkg.
module fed_back (
  input  logic                      clk,
  input  logic                      rst,
  input  fed_pkg::group_t           head,
  input  logic                      q_empty,
  output logic                      q_pop,
  input  logic                      pop,
  output logic                      empty,
  output logic [7:0]                out_byte,
  output logic [fed_pkg::LEN_W-1:0] length_so_far,
  output logic                      last_out
);

  logic [1:0]                sub;
  logic [fed_pkg::LEN_W-1:0] len;
  logic [fed_pkg::LEN_W-1:0] len_next;
  logic                      group_end;
  logic                      take;

  assign empty     = q_empty;
  assign group_end = (sub == head.cnt - 2'd1);
  assign take      = pop && !q_empty;
  assign q_pop     = take && group_end;
  assign out_byte  = head.data[sub];
  assign last_out  = head.last && group_end;
  assign len_next  = (len < fed_pkg::LEN_W'(fed_pkg::MAX_NAME_LEN)) ? len + 1'b1 : len;
  assign length_so_far = len_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      sub <= 2'd0;
      len <= '0;
    end else if (take) begin
      sub <= group_end ? 2'd0 : sub + 2'd1;
      len <= last_out ? '0 : len_next;
    end
  end

endmodule

/* hw/rtl/fed_checker.sv */
// Port-level checker for the filename escape decoder, bound to the top level.
// Depends on fed_pkg and filename_escape_decoder_core.
module fed_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      push,
  input logic                      full,
  input logic                      last_in,
  input logic                      empty,
  input logic                      pop,
  input logic [fed_pkg::LEN_W-1:0] length_so_far,
  input logic                      last_out
);

  localparam logic [fed_pkg::LEN_W-1:0] LEN_MAX = fed_pkg::LEN_W'(fed_pkg::MAX_NAME_LEN);

  // Reset empties the result side
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result side not empty after reset");

  // Running length stays within one and the maximum
  a_len_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (length_so_far != '0 && length_so_far <= LEN_MAX))
    else $error("length out of range");

  // Within a name the length advances by one until it saturates
  a_len_step: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !last_out) |=>
      (empty || length_so_far == $past(length_so_far) + 1'b1 ||
       ($past(length_so_far) == LEN_MAX && length_so_far == LEN_MAX)))
    else $error("length did not advance");

  // A new name restarts the length at one
  a_len_restart: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && last_out) |=> (empty || length_so_far == 1))
    else $error("length did not restart");

  // The final byte of a name always yields a result
  a_last_yields: assert property (@(posedge clk) disable iff (rst)
    (push && !full && last_in) |=> !empty)
    else $error("final byte gave no result");

endmodule

bind filename_escape_decoder_core fed_checker u_fed_checker (.*);
